// ===== hw/rtl/rtc_pkg.sv =====
`default_nettype none
package rtc_pkg;

	// input word: one tick, read or write
	typedef struct packed {
		logic [1:0] action;
		logic [4:0] reg_addr;
		logic [7:0] write_data;
	} req_word_t;

	// result word
	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
	} rsp_word_t;

	// action codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	// register map
	localparam logic [2:0] R_CSEC  = 3'd0;
	localparam logic [2:0] R_HOUR  = 3'd1;
	localparam logic [2:0] R_MIN   = 3'd2;
	localparam logic [2:0] R_SEC   = 3'd3;
	localparam logic [2:0] R_MONTH = 3'd4;
	localparam logic [2:0] R_DAY   = 3'd5;
	localparam logic [2:0] R_YEAR  = 3'd6;
	localparam logic [2:0] R_DOW   = 3'd7;
	localparam logic [4:0] A_RAM   = 5'd8;
	localparam logic [4:0] A_INT   = 5'd16;
	localparam logic [4:0] A_CMD   = 5'd17;

	// command and status bits
	localparam int unsigned CMD_RUN_BIT = 3;
	localparam int unsigned CMD_IE_BIT  = 4;
	localparam logic [7:0]  CMD_RESET   = 8'h0C;
	localparam logic [7:0]  ST_ALARM    = 8'h01;
	localparam logic [7:0]  ST_PEND     = 8'h80;

	// counter reset: 2000-01-01 00:00:00.00, Saturday
	localparam logic [7:0] CNT_RESET [8] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd6};

	// periodic rates: mask bits 1..6, interval in ticks
	localparam int unsigned NUM_RATES = 6;
	localparam logic [23:0] RATE_TICKS [NUM_RATES] = '{
		24'd1, 24'd10, 24'd100, 24'd6000, 24'd360000, 24'd8640000
	};

	// control from the decode to the time counter block
	typedef struct packed {
		logic       tick;
		logic       wr;
		logic       snap;
		logic [2:0] idx;
		logic [7:0] data;
	} clk_ctl_t;

	// control from the decode to the interrupt block
	typedef struct packed {
		logic       tick;
		logic       st_rd;
		logic       mask_wr;
		logic       ie;
		logic [7:0] data;
	} irq_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rtc_if.sv =====
`default_nettype none
// request channel
interface rtc_req_if;
	logic                 valid;
	logic                 ready;
	rtc_pkg::req_word_t   word;
	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface

// response channel
interface rtc_rsp_if;
	logic                 valid;
	logic                 ready;
	rtc_pkg::rsp_word_t   word;
	modport source (output valid, output word, input ready);
	modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rtc_clock.sv =====
`default_nettype none
module rtc_clock (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire rtc_pkg::clk_ctl_t ctl,
	output logic [7:0]             rd_data
);
	import rtc_pkg::*;

	logic [7:0] cnt_q   [8];
	logic [7:0] latch_q [8];
	logic [7:0] cnt_nxt [8];

	// one field increment: {wrap, new value}
	function automatic logic [8:0] bump(input logic [7:0] v, input logic [8:0] limit,
			input logic [7:0] first);
		logic [8:0] s;
		s = {1'b0, v} + 9'd1;
		if (s >= limit) begin
			bump = {1'b1, first};
		end else begin
			bump = {1'b0, s[7:0]};
		end
	endfunction

	// month length; bad months count as 31
	function automatic logic [8:0] month_len(input logic [7:0] m, input logic [7:0] yr);
		logic [8:0] d;
		unique case (m)
			8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = 9'd31;
			8'd4, 8'd6, 8'd9, 8'd11:                    d = 9'd30;
			8'd2:                                        d = (yr[1:0] == 2'b00) ? 9'd29 : 9'd28;
			default:                                     d = 9'd31;
		endcase
		month_len = d;
	endfunction

	// carry chain of one tick
	always_comb begin
		logic [8:0] r;
		logic       c;
		for (int i = 0; i < 8; i++) begin
			cnt_nxt[i] = cnt_q[i];
		end
		r = bump(cnt_q[R_CSEC], 9'd100, 8'd0);
		cnt_nxt[R_CSEC] = r[7:0];
		c = r[8];
		if (c) begin
			r = bump(cnt_q[R_SEC], 9'd60, 8'd0);
			cnt_nxt[R_SEC] = r[7:0];
			c = r[8];
		end
		if (c) begin
			r = bump(cnt_q[R_MIN], 9'd60, 8'd0);
			cnt_nxt[R_MIN] = r[7:0];
			c = r[8];
		end
		if (c) begin
			r = bump(cnt_q[R_HOUR], 9'd24, 8'd0);
			cnt_nxt[R_HOUR] = r[7:0];
			c = r[8];
		end
		if (c) begin
			r = bump(cnt_q[R_DOW], 9'd7, 8'd0);
			cnt_nxt[R_DOW] = r[7:0];
			r = bump(cnt_q[R_DAY], month_len(cnt_q[R_MONTH], cnt_q[R_YEAR]) + 9'd1, 8'd1);
			cnt_nxt[R_DAY] = r[7:0];
			c = r[8];
		end
		if (c) begin
			r = bump(cnt_q[R_MONTH], 9'd13, 8'd1);
			cnt_nxt[R_MONTH] = r[7:0];
			c = r[8];
		end
		if (c) begin
			r = bump(cnt_q[R_YEAR], 9'd100, 8'd0);
			cnt_nxt[R_YEAR] = r[7:0];
		end
	end

	// counters and read latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				cnt_q[i]   <= CNT_RESET[i];
				latch_q[i] <= CNT_RESET[i];
			end
		end else if (en) begin
			if (ctl.tick) begin
				cnt_q <= cnt_nxt;
			end else if (ctl.wr) begin
				cnt_q[ctl.idx] <= ctl.data;
			end
			if (ctl.snap) begin
				latch_q <= cnt_q;
			end
		end
	end

	// hundredths read sees the live counter, the rest read the latch
	assign rd_data = ctl.snap ? cnt_q[R_CSEC] : latch_q[ctl.idx];

endmodule
`default_nettype wire

// ===== hw/rtl/rtc_irq.sv =====
`default_nettype none
module rtc_irq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire rtc_pkg::irq_ctl_t ctl,
	output logic [7:0]             status,
	output logic                   level
);
	import rtc_pkg::*;

	logic [7:0]  status_q;
	logic [7:0]  mask_q;
	logic [23:0] period_q;
	logic [7:0]  status_nxt;
	logic [7:0]  mask_nxt;
	logic [23:0] period_nxt;
	logic [23:0] interval;
	logic [23:0] period_inc;

	// fastest enabled rate
	always_comb begin
		interval = '0;
		for (int i = NUM_RATES - 1; i >= 0; i--) begin
			if (mask_q[i + 1]) begin
				interval = RATE_TICKS[i];
			end
		end
	end

	assign period_inc = period_q + 24'd1;

	// next status, mask and period count
	always_comb begin
		status_nxt = status_q;
		mask_nxt   = mask_q;
		period_nxt = period_q;
		if (ctl.tick && (interval != '0)) begin
			if (period_inc >= interval) begin
				period_nxt = '0;
				status_nxt = status_q | (mask_q & ~ST_ALARM);
			end else begin
				period_nxt = period_inc;
			end
		end
		if (ctl.st_rd) begin
			status_nxt = '0;
		end
		if (ctl.mask_wr) begin
			mask_nxt   = ctl.data & ~ST_PEND;
			period_nxt = '0;
		end
	end

	assign level = ctl.ie && ((status_nxt & mask_nxt) != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			mask_q   <= '0;
			period_q <= '0;
		end else if (en) begin
			status_q <= level ? (status_nxt | ST_PEND) : status_nxt;
			mask_q   <= mask_nxt;
			period_q <= period_nxt;
		end
	end

	assign status = status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/rtc_calendar_with_periodic_irq.sv =====
// A word accepted into the input register is applied when the output register
// is free or draining, and its result is then loaded into the output register.
// Throughput: one word per cycle while responses are taken; while a response
// waits the input register takes one more word, then the input stalls.
// Reset: arst_n clears the clock to 2000-01-01 00:00:00.00 Saturday, RAM and
// interrupt state to zero and the command byte to 0x0C.
`default_nettype none
module rtc_calendar_with_periodic_irq #(
	parameter int unsigned RAM_BYTES = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rtc_req_if.sink    req,
	rtc_rsp_if.source  rsp
);
	import rtc_pkg::*;

	localparam int unsigned RAM_AW = $clog2(RAM_BYTES);
	localparam logic [5:0]  RAM_END = 6'(A_RAM) + 6'(RAM_BYTES);

	logic                vld_s1;
	req_word_t           word_s1;
	logic                adv;
	rsp_word_t           rsp_q;
	logic                rsp_vld_q;
	logic [7:0]          cmd_q;
	logic [7:0]          ram_q [RAM_BYTES];

	logic                is_tick, is_rd, is_wr;
	logic                is_cnt, is_ram;
	logic [RAM_AW-1:0]   ram_idx;
	logic [7:0]          cmd_nxt;
	logic [7:0]          cnt_rd;
	logic [7:0]          st_rd;
	logic                irq_lvl;
	logic [7:0]          rd_data;
	clk_ctl_t            clk_ctl;
	irq_ctl_t            irq_ctl;

	// handshake: stage 1 moves when the output register is free or draining
	assign adv       = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			word_s1 <= req.word;
		end
	end

	// decode
	assign is_tick = (word_s1.action == ACT_TICK) && cmd_q[CMD_RUN_BIT];
	assign is_rd   = (word_s1.action == ACT_READ);
	assign is_wr   = (word_s1.action == ACT_WRITE);
	assign is_cnt  = (word_s1.reg_addr[4:3] == 2'b00);
	assign is_ram  = ({1'b0, word_s1.reg_addr} >= 6'(A_RAM))
		&& ({1'b0, word_s1.reg_addr} < RAM_END);
	assign ram_idx = RAM_AW'(word_s1.reg_addr - A_RAM);
	assign cmd_nxt = (is_wr && word_s1.reg_addr == A_CMD) ? word_s1.write_data : cmd_q;

	assign clk_ctl = '{
		tick: is_tick,
		wr:   is_wr && is_cnt,
		snap: is_rd && word_s1.reg_addr == {2'b00, R_CSEC},
		idx:  word_s1.reg_addr[2:0],
		data: word_s1.write_data
	};

	assign irq_ctl = '{
		tick:    is_tick,
		st_rd:   is_rd && word_s1.reg_addr == A_INT,
		mask_wr: is_wr && word_s1.reg_addr == A_INT,
		ie:      cmd_nxt[CMD_IE_BIT],
		data:    word_s1.write_data
	};

	rtc_clock u_clock (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl     (clk_ctl),
		.rd_data (cnt_rd)
	);

	rtc_irq u_irq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ctl    (irq_ctl),
		.status (st_rd),
		.level  (irq_lvl)
	);

	// command byte and user RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_RESET;
			for (int i = 0; i < RAM_BYTES; i++) begin
				ram_q[i] <= '0;
			end
		end else if (adv) begin
			cmd_q <= cmd_nxt;
			if (is_wr && is_ram) begin
				ram_q[ram_idx] <= word_s1.write_data;
			end
		end
	end

	// read mux
	always_comb begin
		rd_data = '0;
		if (is_rd) begin
			priority if (is_cnt) begin
				rd_data = cnt_rd;
			end else if (is_ram) begin
				rd_data = ram_q[ram_idx];
			end else if (word_s1.reg_addr == A_INT) begin
				rd_data = st_rd;
			end else if (word_s1.reg_addr == A_CMD) begin
				rd_data = cmd_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= '{read_data: rd_data, irq_level: irq_lvl};
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.word  = rsp_q;

	// a raised line always leaves the pending bit set and the enable on
	a_irq_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && rsp_q.irq_level |-> st_rd[7] && cmd_q[CMD_IE_BIT])
		else $error("irq high without pending bit or enable");

	// status read leaves status cleared
	a_st_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && irq_ctl.st_rd |=> st_rd == '0)
		else $error("status not cleared by read");

	// the alarm status bit is never set
	a_no_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		!st_rd[0])
		else $error("alarm status bit set");

	// every applied word produces a response
	a_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_vld_q)
		else $error("applied word lost its response");

endmodule
`default_nettype wire
